/* design/mdfg_pkg.sv */
// Package for the morphing digit frame generator.
// Holds the item types, the row counts and the two constant font tables.
// Depends on nothing.
`default_nettype none

package mdfg_pkg;

  localparam int LARGE_ROWS = 15;
  localparam int SMALL_ROWS = 7;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [3:0] from_digit;
    logic [3:0] to_digit;
    logic [2:0] anim_step;
    logic       small_size;
  } frame_req_t;

  typedef struct packed {
    logic [3:0] row_index;
    logic [7:0] row_pixels;
    logic       last_row;
  } row_item_t;

  localparam logic [7:0] FONT_LARGE [10][LARGE_ROWS] = '{
    '{8'h7E,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h00,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h7E},
    '{8'h00,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h00,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h00},
    '{8'h7E,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h7E,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h7E},
    '{8'h7E,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h7E,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h7E},
    '{8'h00,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h7E,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h00},
    '{8'h7E,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h7E,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h7E},
    '{8'h7E,8'h80,8'h80,8'h80,8'h80,8'h80,8'h80,8'h7E,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h7E},
    '{8'h7E,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h00,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h00},
    '{8'h7E,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h7E,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h7E},
    '{8'h7E,8'h81,8'h81,8'h81,8'h81,8'h81,8'h81,8'h7E,8'h01,8'h01,8'h01,8'h01,8'h01,8'h01,8'h7E}
  };

  localparam logic [7:0] FONT_SMALL [10][SMALL_ROWS] = '{
    '{8'h06,8'h09,8'h09,8'h00,8'h09,8'h09,8'h06},
    '{8'h00,8'h01,8'h01,8'h00,8'h01,8'h01,8'h00},
    '{8'h06,8'h01,8'h01,8'h06,8'h08,8'h08,8'h06},
    '{8'h06,8'h01,8'h01,8'h06,8'h01,8'h01,8'h06},
    '{8'h00,8'h09,8'h09,8'h06,8'h01,8'h01,8'h00},
    '{8'h06,8'h08,8'h08,8'h06,8'h01,8'h01,8'h06},
    '{8'h06,8'h08,8'h08,8'h06,8'h09,8'h09,8'h06},
    '{8'h06,8'h01,8'h01,8'h00,8'h01,8'h01,8'h00},
    '{8'h06,8'h09,8'h09,8'h06,8'h09,8'h09,8'h06},
    '{8'h06,8'h09,8'h09,8'h06,8'h01,8'h01,8'h06}
  };

  // Digits above nine and rows past the end of the font read as blank.
  function automatic logic [7:0] font_row(input logic [3:0] digit, input logic small_font,
                                          input logic [3:0] row);
    logic [7:0] v;
    v = 8'h00;
    if (digit <= 4'd9) begin
      if (small_font) begin
        if (row < 4'(SMALL_ROWS)) begin
          v = FONT_SMALL[digit][row[2:0]];
        end
      end else begin
        if (row < 4'(LARGE_ROWS)) begin
          v = FONT_LARGE[digit][row];
        end
      end
    end
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/mdfg_stream_if.sv */
// Valid/ready stream interface used for the request and row channels.
// The payload type is a parameter; depends on nothing else.
`default_nettype none

interface mdfg_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/mdfg_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// Width and depth are parameters; depends on nothing else.
`default_nettype none

module mdfg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/morphing_digit_frame_generator.sv */
// Top level of the morphing digit frame generator.
// Depends on mdfg_pkg, mdfg_stream_if and mdfg_ram.
//
// Each frame request item yields one row item per font row, top row first: 15 rows for
// the large font and 7 for the small one, with last_row set on the final row. Rows leave
// at one per cycle, built by the row sequencer, while row_out.ready does not stall them.
// Requests wait in a queue of QUEUE_DEPTH entries held in a RAM; the user must keep
// QUEUE_DEPTH a power of two, which the block does not check. The next request is
// fetched while the current frame is still being emitted, so frames follow each other
// without gaps. A request accepted into an empty block goes to the queue RAM, its
// registered read port, the current frame register and the output row register in turn.
`default_nettype none

module morphing_digit_frame_generator #(
  parameter int QUEUE_DEPTH = mdfg_pkg::QUEUE_DEPTH
) (
  input wire logic clk,
  input wire logic rst,
  mdfg_stream_if.sink   frame_in,
  mdfg_stream_if.source row_out
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam logic [3:0] LAST_LARGE = 4'(mdfg_pkg::LARGE_ROWS - 1);
  localparam logic [3:0] LAST_SMALL = 4'(mdfg_pkg::SMALL_ROWS - 1);

  logic [AW:0]   wr_ptr;
  logic [AW:0]   rd_ptr;
  logic [AW:0]   count;
  logic          wr_en;
  logic          rd_en;
  logic [$bits(mdfg_pkg::frame_req_t)-1:0] rd_data;
  logic          hold_valid;
  mdfg_pkg::frame_req_t hold;
  logic          consume;

  mdfg_pkg::frame_req_t cur;
  logic          cur_valid;
  logic [3:0]    row;
  logic          cur_last;
  logic          out_free;
  logic          out_valid;
  mdfg_pkg::row_item_t out_item;
  logic [7:0]    pixels;

  assign count = wr_ptr - rd_ptr;
  assign frame_in.ready = (count != (AW+1)'(QUEUE_DEPTH));
  assign wr_en = frame_in.valid && frame_in.ready;

  assign hold = mdfg_pkg::frame_req_t'(rd_data);
  assign out_free = !out_valid || row_out.ready;
  assign cur_last = (row == (cur.small_size ? LAST_SMALL : LAST_LARGE));
  assign consume = hold_valid && (!cur_valid || (out_free && cur_last));
  assign rd_en = (count != '0) && (!hold_valid || consume);

  mdfg_ram #(
    .WIDTH ($bits(mdfg_pkg::frame_req_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ptr[AW-1:0]),
    .wr_data (frame_in.data),
    .rd_en   (rd_en),
    .rd_addr (rd_ptr[AW-1:0]),
    .rd_data (rd_data)
  );

  function automatic logic [7:0] morph_row(input logic [7:0] s, input logic [7:0] t,
                                           input logic [2:0] k, input logic small_font);
    logic [7:0] both;
    logic [7:0] left;
    logic [7:0] line;
    logic [7:0] grow;
    logic [7:0] shl;
    logic [7:0] shr;
    logic [7:0] v;
    both = small_font ? 8'h09 : 8'h81;
    left = small_font ? 8'h08 : 8'h80;
    line = small_font ? 8'h06 : 8'h7E;
    grow = small_font ? 8'h60 : 8'h7E;
    shl = s << k;
    shr = s >> k;
    if (s == t) begin
      v = s;
    end else if (s == both && t == 8'h01) begin
      v = shr | t;
    end else if (s == both && t == left) begin
      v = shl | t;
    end else if (s == 8'h01 && t == left) begin
      v = shl;
    end else if (s == 8'h01 && t == both) begin
      v = shl | s;
    end else if (s == left && t == 8'h01) begin
      v = shr;
    end else if (s == left && t == both) begin
      v = shr | s;
    end else if (s == line && t == 8'h00) begin
      v = shr;
    end else if (s == 8'h00 && t == line) begin
      v = grow >> (3'd7 - k);
    end else begin
      v = s;
    end
    return v;
  endfunction

  always_comb begin
    logic [7:0] m;
    logic [7:0] r;
    m = morph_row(mdfg_pkg::font_row(cur.from_digit, cur.small_size, row),
                  mdfg_pkg::font_row(cur.to_digit, cur.small_size, row),
                  cur.anim_step, cur.small_size);
    for (int j = 0; j < 8; j++) begin
      r[7-j] = m[j];
    end
    pixels = cur.small_size ? (r >> 4) : r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      hold_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
        hold_valid <= 1'b1;
      end else if (consume) begin
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      row <= '0;
    end else begin
      if (cur_valid && out_free) begin
        out_valid <= 1'b1;
      end else if (row_out.ready) begin
        out_valid <= 1'b0;
      end
      if (consume) begin
        cur_valid <= 1'b1;
        row <= '0;
      end else if (cur_valid && out_free) begin
        if (cur_last) begin
          cur_valid <= 1'b0;
        end else begin
          row <= row + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      cur <= hold;
    end
    if (cur_valid && out_free) begin
      out_item.row_index <= row;
      out_item.row_pixels <= pixels;
      out_item.last_row <= cur_last;
    end
  end

  assign row_out.valid = out_valid;
  assign row_out.data = out_item;

`ifndef NO_ASSERTIONS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(QUEUE_DEPTH))
    else $error("Request queue holds more items than its depth.");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> count != '0)
    else $error("Request queue read while empty.");

  a_row_hold: assert property (@(posedge clk) disable iff (rst)
    cur_valid && !out_free |=> $stable(row) && cur_valid)
    else $error("Row counter moved while the output was stalled.");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    row_out.valid && row_out.data.last_row |->
      row_out.data.row_index == LAST_SMALL || row_out.data.row_index == LAST_LARGE)
    else $error("Last row flagged on a row that ends no frame.");
`endif

endmodule

`default_nettype wire
